[rtl/core/spsd_pkg.sv]
// Shared widths and types for the scalar product share dealer.
// No dependencies; every other file in rtl/core imports this package.
`default_nettype none
package spsd_pkg;
    // low bits of each random word that take part in the math
    localparam int RAND_WIDTH = 31;
    localparam int RAND_IN_W  = 31;
    localparam int DOM_W      = 32;
    localparam int MOD_W      = DOM_W + 1;      // a zero domain stands for 2^32
    localparam int MASK_W     = 31;
    localparam int SHARE_W    = 62;
    localparam int PROD_W     = 2 * RAND_WIDTH;

    typedef logic [RAND_WIDTH-1:0] t_rand;
    typedef logic [MOD_W-1:0]      t_mod;
    typedef logic [PROD_W-1:0]     t_prod;
endpackage
`default_nettype wire

[rtl/core/spsd_ifs.sv]
// Handshake channels of the share dealer: random words in, shares out,
// domain register writes. Depends on spsd_pkg.
`default_nettype none
interface spsd_in_if import spsd_pkg::*;;
    logic                 valid;
    logic                 ready;
    logic [RAND_IN_W-1:0] rand_first;
    logic [RAND_IN_W-1:0] rand_second;
    logic [RAND_IN_W-1:0] rand_split;
    modport source (output valid, rand_first, rand_second, rand_split, input ready);
    modport sink   (input valid, rand_first, rand_second, rand_split, output ready);
endinterface

interface spsd_out_if import spsd_pkg::*;;
    logic               valid;
    logic               ready;
    logic [MASK_W-1:0]  mask_first;
    logic [MASK_W-1:0]  mask_second;
    logic [SHARE_W-1:0] share_first;
    logic [SHARE_W-1:0] share_second;
    modport source (output valid, mask_first, mask_second, share_first, share_second,
                    input ready);
    modport sink   (input valid, mask_first, mask_second, share_first, share_second,
                    output ready);
endinterface

interface spsd_cfg_if import spsd_pkg::*;;
    logic             valid;
    logic             ready;
    logic [DOM_W-1:0] data;
    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface
`default_nettype wire

[rtl/core/spsd_mask_div.sv]
// Pipelined restoring divider: three remainders mod the domain, one bit per stage.
// Depends on spsd_pkg.
`default_nettype none
module spsd_mask_div import spsd_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_en,
    input  wire logic i_valid,
    input  wire t_rand i_ra,
    input  wire t_rand i_rb,
    input  wire t_rand i_rs,
    input  wire t_mod  i_mod,
    output logic  o_valid,
    output t_rand o_rem_a,
    output t_rand o_rem_b,
    output t_rand o_rem_s,
    output t_rand o_rs
);
    t_rand r_rem [RAND_WIDTH][3];
    t_rand r_num [RAND_WIDTH][3];
    logic  r_v   [RAND_WIDTH];

    for (genvar s = 0; s < RAND_WIDTH; s++) begin : g_stage
        t_rand w_rem_in [3];
        t_rand w_num_in [3];
        t_rand n_rem    [3];
        logic  w_v_in;

        if (s == 0) begin : g_head
            assign w_v_in      = i_valid;
            assign w_num_in[0] = i_ra;
            assign w_num_in[1] = i_rb;
            assign w_num_in[2] = i_rs;
            for (genvar k = 0; k < 3; k++) begin : g_zero
                assign w_rem_in[k] = '0;
            end
        end else begin : g_body
            assign w_v_in = r_v[s-1];
            for (genvar k = 0; k < 3; k++) begin : g_link
                assign w_num_in[k] = r_num[s-1][k];
                assign w_rem_in[k] = r_rem[s-1][k];
            end
        end

        // shift in the next dividend bit, subtract the modulus if it fits
        for (genvar k = 0; k < 3; k++) begin : g_lane
            t_rand w_try;
            assign w_try    = {w_rem_in[k][RAND_WIDTH-2:0], w_num_in[k][RAND_WIDTH-1-s]};
            assign n_rem[k] = (t_mod'(w_try) >= i_mod) ? w_try - t_rand'(i_mod) : w_try;
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[s] <= 1'b0;
            end else if (i_en) begin
                r_v[s] <= w_v_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                for (int k = 0; k < 3; k++) begin
                    r_rem[s][k] <= n_rem[k];
                    r_num[s][k] <= w_num_in[k];
                end
            end
        end
    end

    assign o_valid = r_v[RAND_WIDTH-1];
    assign o_rem_a = r_rem[RAND_WIDTH-1][0];
    assign o_rem_b = r_rem[RAND_WIDTH-1][1];
    assign o_rem_s = r_rem[RAND_WIDTH-1][2];
    assign o_rs    = r_num[RAND_WIDTH-1][2];
endmodule
`default_nettype wire

[rtl/core/spsd_mul_split.sv]
// Mask product stage followed by a pipelined restoring divider for split mod product.
// Depends on spsd_pkg.
`default_nettype none
module spsd_mul_split import spsd_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_en,
    input  wire logic i_valid,
    input  wire t_rand i_a,
    input  wire t_rand i_b,
    input  wire t_rand i_sm,
    input  wire t_rand i_rs,
    output logic  o_valid,
    output t_rand o_a,
    output t_rand o_b,
    output t_rand o_sm,
    output t_rand o_rem,
    output t_prod o_p
);
    // product stage
    logic  r_vm;
    t_prod r_pm;
    t_rand r_am, r_bm, r_smm, r_rsm;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vm <= 1'b0;
        end else if (i_en) begin
            r_vm <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_pm  <= PROD_W'(i_a) * PROD_W'(i_b);
            r_am  <= i_a;
            r_bm  <= i_b;
            r_smm <= i_sm;
            r_rsm <= i_rs;
        end
    end

    // division stages, one bit of rand_split per stage
    logic  r_v   [RAND_WIDTH];
    t_rand r_rem [RAND_WIDTH];
    t_rand r_num [RAND_WIDTH];
    t_prod r_p   [RAND_WIDTH];
    t_rand r_a   [RAND_WIDTH];
    t_rand r_b   [RAND_WIDTH];
    t_rand r_sm  [RAND_WIDTH];

    for (genvar s = 0; s < RAND_WIDTH; s++) begin : g_stage
        logic  w_v_in;
        t_rand w_rem_in, w_num_in, w_a_in, w_b_in, w_sm_in, w_try, n_rem;
        t_prod w_p_in;

        if (s == 0) begin : g_head
            assign w_v_in   = r_vm;
            assign w_rem_in = '0;
            assign w_num_in = r_rsm;
            assign w_p_in   = r_pm;
            assign w_a_in   = r_am;
            assign w_b_in   = r_bm;
            assign w_sm_in  = r_smm;
        end else begin : g_body
            assign w_v_in   = r_v[s-1];
            assign w_rem_in = r_rem[s-1];
            assign w_num_in = r_num[s-1];
            assign w_p_in   = r_p[s-1];
            assign w_a_in   = r_a[s-1];
            assign w_b_in   = r_b[s-1];
            assign w_sm_in  = r_sm[s-1];
        end

        assign w_try = {w_rem_in[RAND_WIDTH-2:0], w_num_in[RAND_WIDTH-1-s]};
        assign n_rem = (PROD_W'(w_try) >= w_p_in) ? w_try - t_rand'(w_p_in) : w_try;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[s] <= 1'b0;
            end else if (i_en) begin
                r_v[s] <= w_v_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[s] <= n_rem;
                r_num[s] <= w_num_in;
                r_p[s]   <= w_p_in;
                r_a[s]   <= w_a_in;
                r_b[s]   <= w_b_in;
                r_sm[s]  <= w_sm_in;
            end
        end
    end

    assign o_valid = r_v[RAND_WIDTH-1];
    assign o_a     = r_a[RAND_WIDTH-1];
    assign o_b     = r_b[RAND_WIDTH-1];
    assign o_sm    = r_sm[RAND_WIDTH-1];
    assign o_rem   = r_rem[RAND_WIDTH-1];
    assign o_p     = r_p[RAND_WIDTH-1];
endmodule
`default_nettype wire

[rtl/core/scalar_product_share_dealer_unit.sv]
// Top level of the scalar product share dealer: domain register, datapath, output word.
// Depends on spsd_pkg, spsd_ifs, spsd_mask_div and spsd_mul_split.
`default_nettype none
// Takes one word of three random values per cycle and returns one word of two masks
// and two additive shares of their product, in order. The pipeline is RAND_WIDTH
// stages of the mask divider, one multiply stage, RAND_WIDTH stages of the split
// divider, and the output register. The whole pipeline holds while an output word
// waits; ready follows that. A domain of zero acts as 2^32. Write the domain only
// while no words are in flight.
module scalar_product_share_dealer_unit import spsd_pkg::*; (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    spsd_in_if.sink    i_in,
    spsd_out_if.source o_out,
    spsd_cfg_if.sink   i_cfg
);
    logic [DOM_W-1:0] r_domain;
    t_mod             w_mod;
    logic             w_en;

    // domain register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_domain <= DOM_W'(1);
        end else if (i_cfg.valid) begin
            r_domain <= i_cfg.data;
        end
    end
    assign i_cfg.ready = 1'b1;
    assign w_mod = {(r_domain == '0), r_domain};

    // global advance
    logic r_o_valid;
    assign w_en       = !r_o_valid || o_out.ready;
    assign i_in.ready = w_en;

    logic  w_md_valid;
    t_rand w_a, w_b, w_sm, w_rs;

    spsd_mask_div u_mask_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (i_in.valid),
        .i_ra    (t_rand'(i_in.rand_first)),
        .i_rb    (t_rand'(i_in.rand_second)),
        .i_rs    (t_rand'(i_in.rand_split)),
        .i_mod   (w_mod),
        .o_valid (w_md_valid),
        .o_rem_a (w_a),
        .o_rem_b (w_b),
        .o_rem_s (w_sm),
        .o_rs    (w_rs)
    );

    logic  w_ms_valid;
    t_rand w_ms_a, w_ms_b, w_ms_sm, w_ms_rem;
    t_prod w_ms_p;

    spsd_mul_split u_mul_split (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_md_valid),
        .i_a     (w_a),
        .i_b     (w_b),
        .i_sm    (w_sm),
        .i_rs    (w_rs),
        .o_valid (w_ms_valid),
        .o_a     (w_ms_a),
        .o_b     (w_ms_b),
        .o_sm    (w_ms_sm),
        .o_rem   (w_ms_rem),
        .o_p     (w_ms_p)
    );

    // share select and subtract into the output register
    logic               w_pz;
    logic [SHARE_W-1:0] n_s1, n_s2;
    logic [MASK_W-1:0]  r_mask_a, r_mask_b;
    logic [SHARE_W-1:0] r_s1, r_s2;

    assign w_pz = (w_ms_p == '0);
    assign n_s1 = w_pz ? SHARE_W'(w_ms_sm) : SHARE_W'(w_ms_rem);
    assign n_s2 = w_pz ? SHARE_W'(w_mod - MOD_W'(w_ms_sm))
                       : SHARE_W'(w_ms_p - PROD_W'(w_ms_rem));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (w_en) begin
            r_o_valid <= w_ms_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_mask_a <= MASK_W'(w_ms_a);
            r_mask_b <= MASK_W'(w_ms_b);
            r_s1     <= n_s1;
            r_s2     <= n_s2;
        end
    end

    assign o_out.valid        = r_o_valid;
    assign o_out.mask_first   = r_mask_a;
    assign o_out.mask_second  = r_mask_b;
    assign o_out.share_first  = r_s1;
    assign o_out.share_second = r_s2;

`ifndef SYNTHESIS
    // both masks nonzero means a nonzero product, so the second share is nonzero
    a_share2_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_o_valid && (r_mask_a != '0) && (r_mask_b != '0) |-> (r_s2 != '0))
        else $error("second share zero for nonzero product");
    // a mask never reaches a nonzero domain
    a_mask_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_o_valid && (r_domain != '0) |->
            (DOM_W'(r_mask_a) < r_domain) && (DOM_W'(r_mask_b) < r_domain))
        else $error("mask not reduced by domain");
    // a waiting output word freezes the whole pipeline, so both shares stay stable
    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_o_valid && !o_out.ready |=> $stable(r_s1) && $stable(r_s2))
        else $error("output word changed under stall");
`endif
endmodule
`default_nettype wire
